[src/lbc_pkg.sv]
// Shared types and constants for the LRU block cache tag and replacement logic.
`default_nettype none

package lbc_pkg;

  localparam int LBC_ENTRIES    = 16;
  localparam int LBC_STAMP_BITS = 32;

  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } lbc_state_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] block_number;
  } lbc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic        fill_needed;
    logic        writeback_needed;
    logic [31:0] writeback_block;
  } lbc_out_t;

  // Lookup token that walks the cell chain; indexes and stamps travel beside it.
  typedef struct packed {
    logic        valid;
    logic [31:0] blk;
    logic        hit;
    logic [31:0] best_tag;
    logic        best_dirty;
  } lbc_tok_t;

  // Entry update broadcast to every cell; the target index travels beside it.
  typedef struct packed {
    logic        en;
    logic        load_tag;
    logic        dirty_we;
    logic        dirty;
    logic [31:0] tag;
  } lbc_upd_t;

endpackage

`default_nettype wire

[src/lbc_cell.sv]
// One cache entry cell: holds tag, stamp and dirty bit and advances the lookup token.
`default_nettype none

module lbc_cell #(
  parameter int IDX_W      = 4,
  parameter int STAMP_BITS = lbc_pkg::LBC_STAMP_BITS,
  parameter int INDEX      = 0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  lbc_pkg::lbc_tok_t        tok_in,
  input  wire  [IDX_W-1:0]         hit_idx_in,
  input  wire  [IDX_W-1:0]         best_idx_in,
  input  wire  [STAMP_BITS-1:0]    best_stamp_in,
  output lbc_pkg::lbc_tok_t        tok_out,
  output logic [IDX_W-1:0]         hit_idx_out,
  output logic [IDX_W-1:0]         best_idx_out,
  output logic [STAMP_BITS-1:0]    best_stamp_out,
  input  lbc_pkg::lbc_upd_t        upd,
  input  wire  [IDX_W-1:0]         upd_idx,
  input  wire  [STAMP_BITS-1:0]    upd_stamp
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [31:0]           tag_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic                  dirty_r;
  logic                  tok_valid_r;
  lbc_pkg::lbc_tok_t     tok_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [STAMP_BITS-1:0] best_stamp_r;

  logic match;
  logic take;
  logic sel;

  assign match = !tok_in.hit && (tag_r == tok_in.blk);
  // The first cell always seeds the minimum, which also covers all stamps at maximum.
  assign take  = (INDEX == 0) || (stamp_r < best_stamp_in);
  assign sel   = (upd_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      stamp_r <= '0;
      dirty_r <= 1'b0;
    end else if (upd.en && sel) begin
      stamp_r <= upd_stamp;
      if (upd.load_tag) begin
        tag_r <= upd.tag;
      end
      if (upd.dirty_we) begin
        dirty_r <= upd.dirty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r.valid <= 1'b0;
    tok_r.blk   <= tok_in.blk;
    tok_r.hit   <= tok_in.hit || match;
    hit_idx_r   <= match ? MY_IDX : hit_idx_in;
    if (take) begin
      tok_r.best_tag   <= tag_r;
      tok_r.best_dirty <= dirty_r;
      best_idx_r       <= MY_IDX;
      best_stamp_r     <= stamp_r;
    end else begin
      tok_r.best_tag   <= tok_in.best_tag;
      tok_r.best_dirty <= tok_in.best_dirty;
      best_idx_r       <= best_idx_in;
      best_stamp_r     <= best_stamp_in;
    end
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = tok_valid_r;
  end

  assign hit_idx_out    = hit_idx_r;
  assign best_idx_out   = best_idx_r;
  assign best_stamp_out = best_stamp_r;

endmodule

`default_nettype wire

[src/lru_block_cache_policy.sv]
// Top level of the LRU block cache tag and replacement logic.
//
// Requests arrive on in_valid/in_ready as an opcode (read or write) and a block
// number; one result per request leaves on out_valid/out_ready with status, the
// entry index, and fill and writeback indications.
// A lookup token walks a chain of ENTRIES cells, one cell per cycle, checking
// for a tag match and tracking the oldest stamp (lowest index on ties). When the
// token leaves the last cell the hit or victim entry is updated and the result
// is registered; it moves to the output register once that is free. One request
// is in flight at a time, so a new request is taken only after the last one has
// left the chain and its result has moved to the output register. Block zero
// skips the chain: its error result is registered at acceptance instead.
// A finished result sits in the output register while the next request is
// accepted and scanned; a stalled receiver only holds back the request after.
// Synchronous reset empties every entry, clears dirty bits, stamps and the use
// clock, and leaves both channels idle.
`default_nettype none

module lru_block_cache_policy #(
  parameter int ENTRIES    = lbc_pkg::LBC_ENTRIES,
  parameter int STAMP_BITS = lbc_pkg::LBC_STAMP_BITS
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  lbc_pkg::lbc_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output lbc_pkg::lbc_out_t out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  lbc_pkg::lbc_tok_t     tok        [0:ENTRIES];
  logic [IDX_W-1:0]      hit_idx    [0:ENTRIES];
  logic [IDX_W-1:0]      best_idx   [0:ENTRIES];
  logic [STAMP_BITS-1:0] best_stamp [0:ENTRIES];

  lbc_pkg::lbc_state_t   state_r, state_nxt;
  logic [STAMP_BITS-1:0] use_clock_r;
  logic                  req_write_r;
  logic [31:0]           req_blk_r;
  lbc_pkg::lbc_out_t     res_r, res_nxt;
  logic                  res_load;
  logic                  out_valid_r;
  lbc_pkg::lbc_out_t     out_data_r;

  lbc_pkg::lbc_upd_t     upd;
  logic [IDX_W-1:0]      upd_idx;

  logic in_fire;
  logic blk_zero;
  logic out_free;
  logic tail_valid;
  logic [IDX_W+3:0] idx_ext;

  assign in_fire    = in_valid && in_ready;
  assign blk_zero   = (in_data.block_number == 32'd0);
  assign out_free   = !out_valid_r || out_ready;
  assign tail_valid = tok[ENTRIES].valid;

  // Seed the token at the head of the chain.
  assign tok[0].valid      = in_fire && !blk_zero;
  assign tok[0].blk        = in_data.block_number;
  assign tok[0].hit        = 1'b0;
  assign tok[0].best_tag   = '0;
  assign tok[0].best_dirty = 1'b0;
  assign hit_idx[0]        = '0;
  assign best_idx[0]       = '0;
  assign best_stamp[0]     = STAMP_MAX;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    lbc_cell #(
      .IDX_W      (IDX_W),
      .STAMP_BITS (STAMP_BITS),
      .INDEX      (k)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .tok_in         (tok[k]),
      .hit_idx_in     (hit_idx[k]),
      .best_idx_in    (best_idx[k]),
      .best_stamp_in  (best_stamp[k]),
      .tok_out        (tok[k+1]),
      .hit_idx_out    (hit_idx[k+1]),
      .best_idx_out   (best_idx[k+1]),
      .best_stamp_out (best_stamp[k+1]),
      .upd            (upd),
      .upd_idx        (upd_idx),
      .upd_stamp      (use_clock_r)
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = blk_zero ? lbc_pkg::ST_HOLD : lbc_pkg::ST_SCAN;
        end
      end
      lbc_pkg::ST_SCAN: begin
        if (tail_valid) begin
          state_nxt = lbc_pkg::ST_HOLD;
        end
      end
      lbc_pkg::ST_HOLD: begin
        if (out_free) begin
          state_nxt = lbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lbc_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == lbc_pkg::ST_IDLE);

  // Error result for block zero; else entry update and result on chain exit.
  always_comb begin
    idx_ext  = '0;
    upd      = '0;
    upd_idx  = '0;
    res_nxt  = '0;
    res_load = 1'b0;
    if (state_r == lbc_pkg::ST_IDLE && in_fire && blk_zero) begin
      res_load       = 1'b1;
      res_nxt.status = lbc_pkg::STATUS_ERR;
    end else if (tail_valid) begin
      res_load = 1'b1;
      upd.en   = 1'b1;
      upd.tag  = req_blk_r;
      if (tok[ENTRIES].hit) begin
        upd_idx        = hit_idx[ENTRIES];
        upd.dirty_we   = req_write_r;
        upd.dirty      = 1'b1;
        idx_ext        = {4'd0, hit_idx[ENTRIES]};
        res_nxt.status = lbc_pkg::STATUS_HIT;
      end else begin
        upd_idx                  = best_idx[ENTRIES];
        upd.load_tag             = 1'b1;
        upd.dirty_we             = 1'b1;
        upd.dirty                = req_write_r;
        idx_ext                  = {4'd0, best_idx[ENTRIES]};
        res_nxt.status           = lbc_pkg::STATUS_MISS;
        res_nxt.fill_needed      = !req_write_r;
        res_nxt.writeback_needed = tok[ENTRIES].best_dirty;
        res_nxt.writeback_block  = tok[ENTRIES].best_dirty ? tok[ENTRIES].best_tag : 32'd0;
      end
      res_nxt.entry_index = idx_ext[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbc_pkg::ST_IDLE;
      use_clock_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (tail_valid) begin
        use_clock_r <= use_clock_r + 1'b1;
      end
      if (state_r == lbc_pkg::ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_write_r <= in_data.opcode;
      req_blk_r   <= in_data.block_number;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
    if (state_r == lbc_pkg::ST_HOLD && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[src/lbc_checker.sv]
// Port-level checks for the LRU block cache, bound to the top level.
`default_nettype none

module lbc_port_checks (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input lbc_pkg::lbc_in_t  in_data,
  input wire               out_valid,
  input wire               out_ready,
  input lbc_pkg::lbc_out_t out_data
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error results carry no other information.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == lbc_pkg::STATUS_ERR |->
      out_data.entry_index == 4'd0 && !out_data.fill_needed &&
      !out_data.writeback_needed && out_data.writeback_block == 32'd0)
    else $error("error result has nonzero fields");

  // Hits never fill or write back; no status code above error.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3) &&
      (out_data.status != lbc_pkg::STATUS_HIT ||
       (!out_data.fill_needed && !out_data.writeback_needed))
    )
    else $error("bad status or hit with fill or writeback");

  // A clean victim reports block zero.
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.writeback_needed |-> out_data.writeback_block == 32'd0)
    else $error("writeback block set without writeback");

  // One request at a time: no accept right after an accept.
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

endmodule

bind lru_block_cache_policy lbc_port_checks u_lbc_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
